>>> src/gspe_pkg.sv
// Shared types, constants and tables of the gas sensor ppm estimator.
// Used by the controller, the datapath, the divider and the top level; no dependencies.
package gspe_pkg;

  localparam int WARMUP_SAMPLES = 10;
  localparam int SAMPLE_MAX     = 4095;

  localparam int V_GATE   = 64 * SAMPLE_MAX;
  localparam int RS_K     = 12800 * SAMPLE_MAX;
  localparam int R0_RESET = 2560;
  localparam int R0_MIN   = 26;
  localparam int R0_MAX   = 25600;
  localparam int RATIO_MIN = 656;
  localparam int PPM_MAX  = 160000;
  localparam int E_BIAS   = -158925 + 4 * 65536;
  localparam int E_TOP    = 18 * 65536;
  localparam int DIV_W    = 64;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_FDIV, OP_FSET, OP_RDIV, OP_RSET, OP_CDIV, OP_CSET,
    OP_LINIT, OP_NORM, OP_SQM, OP_SQU, OP_LDIV, OP_ESET, OP_EMUL, OP_EUPD,
    OP_ESKIP, OP_PZERO, OP_PMAX, OP_PFIN, OP_OUT, OP_FAVG, OP_LSCL
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_FWAIT, ST_GATE, ST_RWAIT, ST_CWAIT, ST_LOG, ST_NORM,
    ST_SQM, ST_SQU, ST_LDIV, ST_LWAIT, ST_ECHK, ST_EMUL, ST_EUPD, ST_FIN, ST_OUT,
    ST_ESET
  } ctrl_state_t;

  typedef struct packed {
    logic smp_cmd;
    logic warmup;
    logic vok;
    logic r0ok;
    logic div_done;
    logic ratio_small;
    logic norm_done;
    logic k_zero;
    logic k_full;
    logic e_neg;
    logic e_big;
    logic ebit;
    logic out_free;
  } dp_status_t;

  // 2^(2^-(k+1)) in Q2.30.
  function automatic logic [31:0] pow2_frac(input logic [3:0] k);
    logic [31:0] v;
    case (k)
      4'd0:    v = 32'd1518500250;
      4'd1:    v = 32'd1276901417;
      4'd2:    v = 32'd1170923762;
      4'd3:    v = 32'd1121280436;
      4'd4:    v = 32'd1097253708;
      4'd5:    v = 32'd1085434106;
      4'd6:    v = 32'd1079572138;
      4'd7:    v = 32'd1076653033;
      4'd8:    v = 32'd1075196444;
      4'd9:    v = 32'd1074468887;
      4'd10:   v = 32'd1074105294;
      4'd11:   v = 32'd1073923544;
      4'd12:   v = 32'd1073832680;
      4'd13:   v = 32'd1073787250;
      4'd14:   v = 32'd1073764537;
      4'd15:   v = 32'd1073753181;
      default: v = 32'd1073741824;
    endcase
    return v;
  endfunction

endpackage

>>> src/gas_sensor_ppm_estimator.sv
// Top level of the gas sensor ppm estimator: stream ports and configuration.
// Depends on gspe_pkg, gspe_ctrl and gspe_datapath.
//
// Usage. Each transfer on the slave stream carries one command: tuser = 0
// filters tdata (a 12-bit converter sample) and, if the gates pass, refreshes
// the resistance ratio; tuser = 1 calibrates the clean-air resistance from
// the present filtered voltage if it passes. Every command yields exactly one
// transfer on the master stream with the filtered level, the ratio Rs/R0,
// the CO estimate and R0. The configuration channel sets R0; cfg_ready
// is always high, and writes are meant for times when no command is in work.
// One command is worked at a time. The time that a command takes is set by
// the 64-step serial divider (running mean, ratio and calibrate each take
// one pass), the bit-at-a-time normalize shift, and the 16 squarings and 16
// table steps of the log2/exp2 chain; the next command can be accepted once
// the result is presented. The steady-state average and the log scaling use
// reciprocal products.
// A finished result sits in the output register; the block takes the next
// command while it waits, and holds its next result until m_tready frees the
// register. Reset (rst, synchronous) clears the filter, warm-up count and
// ratio, sets R0 to 10 kOhm and empties the output.
module gas_sensor_ppm_estimator import gspe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] sample, zero fill above
  input  logic [0:0]  s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  // [19:0] filtered_level, [51:20] resistance_ratio, [69:52] co_ppm,
  // [84:70] reference_resistance, zero fill above
  output logic [87:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  dp_op_t      op;
  dp_status_t  status;
  logic [19:0] level;
  logic [31:0] ratio;
  logic [17:0] ppm;
  logic [14:0] r0;

  assign cfg_ready = 1'b1;

  gspe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .op       (op)
  );

  gspe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .in_cmd    (s_tuser[0]),
    .in_sample (s_tdata[11:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_level (level),
    .out_ratio (ratio),
    .out_ppm   (ppm),
    .out_r0    (r0)
  );

  assign m_tdata = {3'b000, r0, ppm, ratio, level};

endmodule

>>> src/gspe_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on gspe_pkg for the operand width.
module gspe_div import gspe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] dsr;
  logic [6:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem[DIV_W-1:0], quotient[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 7'd1;
      if (cnt == 7'(DIV_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, dsr} : rem_sh;
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule

>>> src/gspe_datapath.sv
// Datapath: filter, resistance ratio, log2/exp2 ppm chain and output register.
// Depends on gspe_pkg and gspe_div; driven by one operation code per cycle.
module gspe_datapath import gspe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  dp_op_t       op,
  output dp_status_t   status,
  input  logic         in_cmd,
  input  logic [11:0]  in_sample,
  input  logic         cfg_we,
  input  logic [14:0]  cfg_value,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [19:0]  out_level,
  output logic [31:0]  out_ratio,
  output logic [17:0]  out_ppm,
  output logic [14:0]  out_r0
);

  logic [19:0]        f;
  logic [3:0]         warm;
  logic [14:0]        r0;
  logic signed [31:0] ratio;
  logic [17:0]        ppm;
  logic               smp_cmd;
  logic [11:0]        smp;
  logic [31:0]        x;
  logic [4:0]         p;
  logic [15:0]        frac;
  logic [3:0]         k;
  logic [63:0]        prod;
  logic               lg_neg;
  logic [31:0]        lg_abs;
  logic signed [33:0] e;
  logic [31:0]        m;

  logic [26:0]        f66;
  logic [27:0]        f165;
  logic signed [28:0] numer;
  logic               num_neg;
  logic [27:0]        num_mag;
  logic               div_start;
  logic [63:0]        div_a;
  logic [63:0]        div_b;
  logic [63:0]        div_q;
  logic               div_done;
  logic               in_warmup;
  logic [24:0]        avg_sum;
  logic [56:0]        avg_prod;
  logic signed [31:0] lg;
  logic signed [41:0] lg276;
  logic [41:0]        lg_mag;
  logic signed [33:0] sq;
  logic [33:0]        t;
  logic [63:0]        v;
  logic [67:0]        v10;
  logic [63:0]        vr;
  logic [15:0]        e_frac;

  assign f66       = 27'(f) * 27'd66;
  assign f165      = 28'(f) * 28'd165;
  assign numer     = 29'(RS_K) - $signed({2'b00, f66});
  assign num_neg   = numer[28];
  assign num_mag   = num_neg ? 28'(-numer) : 28'(numer);
  assign in_warmup = warm < 4'(WARMUP_SAMPLES);
  // Exponential average: (7*f + 768*x) / 10 by reciprocal multiplication,
  // exact for any dividend below 2^32.
  assign avg_sum   = 25'(f) * 25'd7 + 25'(smp) * 25'd768;
  assign avg_prod  = 57'(avg_sum) * 57'd3435973837;
  assign lg        = $signed(((32'(p) - 32'd16) << 16) | 32'(frac));
  assign lg276     = 42'(lg) * 42'sd276;
  assign lg_mag    = lg276[41] ? 42'(-lg276) : 42'(lg276);
  assign t         = prod[63:30];
  assign e_frac    = e[15:0];
  assign v         = 64'(m) << e[20:16];
  assign v10       = 68'(v) * 68'd10;
  assign vr        = (v + 64'd536870912) >> 30;
  // The scaled log divided by 100 sits in prod[63:37] after OP_LSCL.
  assign sq        = lg_neg ? -$signed(34'(prod[63:37])) : $signed(34'(prod[63:37]));

  always_comb begin
    div_start = 1'b1;
    div_a     = '0;
    div_b     = 64'd1;
    case (op)
      OP_FDIV: begin
        div_a = 64'(f) * 64'(warm) + (64'(smp) << 8);
        div_b = 64'(warm) + 64'd1;
      end
      OP_RDIV: begin
        div_a = (64'(num_mag) * 64'd10) << 24;
        div_b = 64'(f66) * 64'(r0);
      end
      OP_CDIV: begin
        div_a = 64'(num_mag) * 64'd2560;
        div_b = 64'(f66);
      end
      default: div_start = 1'b0;
    endcase
  end

  gspe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f     <= '0;
      warm  <= '0;
      r0    <= 15'(R0_RESET);
      ratio <= '0;
    end else if (cfg_we) begin
      r0 <= cfg_value;
    end else begin
      case (op)
        OP_FSET: begin
          f <= (div_q > 64'hFFFFF) ? 20'hFFFFF : div_q[19:0];
          if (in_warmup) warm <= warm + 4'd1;
        end
        OP_FAVG: f <= avg_prod[54:35];
        OP_RSET: begin
          if (!num_neg) begin
            ratio <= (div_q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(div_q[31:0]);
          end else begin
            ratio <= (div_q >= 64'h80000000) ? 32'sh80000000 : -$signed(div_q[31:0]);
          end
        end
        OP_CSET: begin
          if (num_neg || div_q < 64'(R0_MIN)) r0 <= 15'(R0_MIN);
          else if (div_q > 64'(R0_MAX))       r0 <= 15'(R0_MAX);
          else                                r0 <= div_q[14:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        smp_cmd <= in_cmd;
        smp     <= in_sample;
      end
      OP_LINIT: begin
        x    <= ratio;
        p    <= 5'd30;
        frac <= '0;
        k    <= 4'd15;
      end
      OP_NORM: begin
        x <= x << 1;
        p <= p - 5'd1;
      end
      OP_SQM: prod <= 64'(x) * 64'(x);
      OP_SQU: begin
        if (t >= 34'h80000000) begin
          x       <= t[32:1];
          frac[k] <= 1'b1;
        end else begin
          x <= t[31:0];
        end
        k <= k - 4'd1;
      end
      OP_LDIV: begin
        lg_neg <= lg276[41];
        lg_abs <= lg_mag[31:0];
      end
      // Division by 100 as a reciprocal multiplication, exact below 2^32.
      OP_LSCL: prod <= 64'(lg_abs) * 64'd1374389535;
      OP_ESET: begin
        e <= 34'(E_BIAS) - sq;
        m <= 32'd1073741824;
        k <= 4'd0;
      end
      OP_EMUL:  prod <= 64'(m) * 64'(pow2_frac(k));
      OP_EUPD: begin
        m <= prod[61:30];
        k <= k + 4'd1;
      end
      OP_ESKIP: k <= k + 4'd1;
      OP_PZERO: ppm <= '0;
      OP_PMAX:  ppm <= 18'(PPM_MAX);
      OP_PFIN: begin
        if (v10 < (68'd16 << 30))      ppm <= '0;
        else if (vr > 64'(PPM_MAX))    ppm <= 18'(PPM_MAX);
        else                           ppm <= vr[17:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      out_level <= f;
      out_ratio <= ratio;
      out_ppm   <= ppm;
      out_r0    <= r0;
    end
  end

  always_comb begin
    status.smp_cmd     = smp_cmd;
    status.warmup      = in_warmup;
    status.vok         = f165 > 28'(V_GATE);
    status.r0ok        = 22'(r0) * 22'd100 > 22'd256;
    status.div_done    = div_done;
    status.ratio_small = ratio < 32'sd656;
    status.norm_done   = x[30];
    status.k_zero      = k == 4'd0;
    status.k_full      = k == 4'd15;
    status.e_neg       = e[33];
    status.e_big       = e >= 34'(E_TOP);
    status.ebit        = e_frac[4'd15 - k];
    status.out_free    = !out_valid || out_ready;
  end

`ifndef ASSERT_OFF
  a_div_result: assert property (@(posedge clk) disable iff (rst)
    (op == OP_FSET || op == OP_RSET || op == OP_CSET) |-> div_done)
    else $error("division result used before the divider finished");
  a_sq_order: assert property (@(posedge clk) disable iff (rst)
    op == OP_SQU |-> $past(op) == OP_SQM)
    else $error("squaring update without a fresh product");
  a_ppm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_ppm <= 18'(PPM_MAX))
    else $error("ppm estimate above its clamp");
`endif

endmodule

>>> src/gspe_ctrl.sv
// Controller state machine sequencing the datapath operations for one item.
// Depends on gspe_pkg for the state, operation and status types.
module gspe_ctrl import gspe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DISP;
      ST_DISP: begin
        if (!status.smp_cmd) state_next = status.warmup ? ST_FWAIT : ST_GATE;
        else if (status.vok) state_next = ST_CWAIT;
        else                 state_next = ST_LOG;
      end
      ST_FWAIT: if (status.div_done) state_next = ST_GATE;
      ST_GATE:  state_next = (status.vok && status.r0ok) ? ST_RWAIT : ST_LOG;
      ST_RWAIT: if (status.div_done) state_next = ST_LOG;
      ST_CWAIT: if (status.div_done) state_next = ST_LOG;
      ST_LOG:   state_next = status.ratio_small ? ST_OUT : ST_NORM;
      ST_NORM:  if (status.norm_done) state_next = ST_SQM;
      ST_SQM:   state_next = ST_SQU;
      ST_SQU:   state_next = status.k_zero ? ST_LDIV : ST_SQM;
      ST_LDIV:  state_next = ST_LWAIT;
      ST_LWAIT: state_next = ST_ESET;
      ST_ESET:  state_next = ST_ECHK;
      ST_ECHK:  state_next = (status.e_neg || status.e_big) ? ST_OUT : ST_EMUL;
      ST_EMUL: begin
        if (status.ebit)        state_next = ST_EUPD;
        else if (status.k_full) state_next = ST_FIN;
      end
      ST_EUPD:  state_next = status.k_full ? ST_FIN : ST_EMUL;
      ST_FIN:   state_next = ST_OUT;
      ST_OUT:   if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LATCH;
      end
      ST_DISP: begin
        if (!status.smp_cmd) op = status.warmup ? OP_FDIV : OP_FAVG;
        else if (status.vok) op = OP_CDIV;
      end
      ST_FWAIT: if (status.div_done) op = OP_FSET;
      ST_GATE:  if (status.vok && status.r0ok) op = OP_RDIV;
      ST_RWAIT: if (status.div_done) op = OP_RSET;
      ST_CWAIT: if (status.div_done) op = OP_CSET;
      ST_LOG:   op = status.ratio_small ? OP_PZERO : OP_LINIT;
      ST_NORM:  if (!status.norm_done) op = OP_NORM;
      ST_SQM:   op = OP_SQM;
      ST_SQU:   op = OP_SQU;
      ST_LDIV:  op = OP_LDIV;
      ST_LWAIT: op = OP_LSCL;
      ST_ESET:  op = OP_ESET;
      ST_ECHK: begin
        if (status.e_neg)      op = OP_PZERO;
        else if (status.e_big) op = OP_PMAX;
      end
      ST_EMUL:  op = status.ebit ? OP_EMUL : OP_ESKIP;
      ST_EUPD:  op = OP_EUPD;
      ST_FIN:   op = OP_PFIN;
      ST_OUT:   if (status.out_free) op = OP_OUT;
      default:  op = OP_NONE;
    endcase
  end

endmodule
